@@ hdl/spmr_pkg.sv @@
// Shared types, constants and the Lehmer step function of the shuffled Park-Miller generator.
package spmr_pkg;

    localparam int unsigned TableSize = 32;
    localparam int unsigned WordW     = 31;

    localparam logic [14:0]    MulA    = 15'd16807;
    localparam logic [30:0]    ModM    = 31'h7FFF_FFFF;
    localparam longint unsigned ModMVal = 64'd2147483647;

    localparam logic CmdDraw = 1'b0;
    localparam logic CmdSeed = 1'b1;

    typedef logic [WordW-1:0] t_word;

    typedef struct packed {
        logic load_seed;
        logic warm_init;
        logic warm_step;
        logic draw_step;
        logic slot_fix;
        logic tbl_read;
        logic swap;
    } t_dp_cmd;

    typedef struct packed {
        logic so_zero;
        logic warm_last;
        logic out_busy;
    } t_dp_status;

    // x' = 16807 * x mod (2^31 - 1), folded at the Mersenne modulus
    function automatic t_word lehmer_step(input t_word x);
        logic [45:0] p;
        logic [31:0] s;
        p = 46'(x) * 46'(MulA);
        s = {1'b0, p[30:0]} + 32'(p[45:31]);
        if (s >= {1'b0, ModM}) begin
            s = s - {1'b0, ModM};
        end
        return s[30:0];
    endfunction

endpackage

@@ hdl/spmr_if.sv @@
// Valid/ready channel interfaces for the command input and the value output.
interface spmr_in_if;
    logic                valid;
    logic                ready;
    logic                cmd;
    spmr_pkg::t_word     seed;

    modport source (output valid, output cmd, output seed, input ready);
    modport sink   (input valid, input cmd, input seed, output ready);
endinterface

interface spmr_out_if;
    logic                valid;
    logic                ready;
    spmr_pkg::t_word     value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

@@ hdl/spmr_ctrl.sv @@
// Control state machine: sequences seeding, table warm-up and shuffled draws.
module spmr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_cmd,
    output logic                  o_in_ready,
    output spmr_pkg::t_dp_cmd     o_cmd,
    input  spmr_pkg::t_dp_status  i_status
);
    import spmr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WINIT,
        S_WARM,
        S_STEP,
        S_FIX,
        S_READ,
        S_SWAP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_cmd == CmdSeed) begin
                        o_cmd.load_seed = 1'b1;
                    end else if (i_status.so_zero) begin
                        n_state = S_WINIT;
                    end else begin
                        n_state = S_STEP;
                    end
                end
            end
            S_WINIT: begin
                o_cmd.warm_init = 1'b1;
                n_state         = S_WARM;
            end
            S_WARM: begin
                o_cmd.warm_step = 1'b1;
                if (i_status.warm_last) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.draw_step = 1'b1;
                n_state         = S_FIX;
            end
            S_FIX: begin
                o_cmd.slot_fix = 1'b1;
                n_state        = S_READ;
            end
            S_READ: begin
                o_cmd.tbl_read = 1'b1;
                n_state        = S_SWAP;
            end
            S_SWAP: begin
                if (!i_status.out_busy) begin
                    o_cmd.swap = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/spmr_dp.sv @@
// Datapath: generator state, shuffle table, slot divider and output register.
module spmr_dp #(
    parameter int unsigned TABLE_SIZE = spmr_pkg::TableSize
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  spmr_pkg::t_dp_cmd     i_cmd,
    output spmr_pkg::t_dp_status  o_status,
    input  spmr_pkg::t_word       i_seed,
    output logic                  o_out_valid,
    output spmr_pkg::t_word       o_out_value,
    input  logic                  i_out_ready
);
    import spmr_pkg::*;

    localparam int unsigned     AW      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int unsigned     CW      = $clog2(TABLE_SIZE + 8);
    localparam int unsigned     QW      = $clog2(TABLE_SIZE) + 2;
    localparam int unsigned     PW      = QW + WordW;
    localparam longint unsigned SlotDiv = 1 + (ModMVal - 1) / TABLE_SIZE;
    localparam longint unsigned Recip   = (64'd1 << WordW) / SlotDiv;

    t_word           r_lcg;
    t_word           r_so;
    logic [CW-1:0]   r_cnt;
    logic [QW-1:0]   r_qest;
    logic [AW-1:0]   r_slot;
    t_word           r_rd;
    logic            r_ov;
    t_word           r_oval;
    t_word           r_mem [TABLE_SIZE];

    t_word           w_next;
    t_word           w_fixed;
    logic [PW-1:0]   w_prod_a;
    logic [PW-1:0]   w_prod_b;
    logic [PW-1:0]   w_rem;
    logic [QW-1:0]   w_q;
    logic [QW-1:0]   w_qsat;
    logic            w_we;
    logic [AW-1:0]   w_waddr;

    assign w_next   = lehmer_step(r_lcg);
    assign w_fixed  = ((r_lcg == '0) || (r_lcg == ModM)) ? t_word'(1) : r_lcg;

    assign w_prod_a = PW'(r_so) * PW'(Recip);
    assign w_prod_b = PW'(r_qest) * PW'(SlotDiv);
    assign w_rem    = PW'(r_so) - w_prod_b;
    assign w_q      = (w_rem >= PW'(SlotDiv)) ? r_qest + QW'(1) : r_qest;
    assign w_qsat   = (w_q > QW'(TABLE_SIZE - 1)) ? QW'(TABLE_SIZE - 1) : w_q;

    assign w_we     = (i_cmd.warm_step && (r_cnt < CW'(TABLE_SIZE))) || i_cmd.swap;
    assign w_waddr  = i_cmd.swap ? r_slot : r_cnt[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= i_cmd.swap ? r_lcg : w_next;
        end
        if (i_cmd.tbl_read) begin
            r_rd <= r_mem[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.warm_init) begin
            r_cnt <= CW'(TABLE_SIZE + 7);
        end else if (i_cmd.warm_step) begin
            r_cnt <= r_cnt - CW'(1);
        end
        if (i_cmd.draw_step) begin
            r_qest <= w_prod_a[PW-1:WordW];
        end
        if (i_cmd.slot_fix) begin
            r_slot <= w_qsat[AW-1:0];
        end
        if (i_cmd.swap) begin
            r_oval <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg <= t_word'(1);
            r_so  <= '0;
            r_ov  <= 1'b0;
        end else begin
            priority if (i_cmd.load_seed) begin
                r_lcg <= i_seed;
                r_so  <= '0;
            end else if (i_cmd.warm_init) begin
                r_lcg <= w_fixed;
            end else if (i_cmd.warm_step || i_cmd.draw_step) begin
                r_lcg <= w_next;
                if (i_cmd.warm_step && (r_cnt == '0)) begin
                    r_so <= w_next;
                end
            end else if (i_cmd.swap) begin
                r_so <= r_rd;
            end else begin
                r_lcg <= r_lcg;
            end
            if (i_cmd.swap) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_status.so_zero   = (r_so == '0);
    assign o_status.warm_last = (r_cnt == '0);
    assign o_status.out_busy  = r_ov && !i_out_ready;

    assign o_out_valid = r_ov;
    assign o_out_value = r_oval;

endmodule

@@ hdl/shuffled_park_miller_rng_top.sv @@
// Top level of the shuffled minimal-standard (Park-Miller, Bays-Durham) generator.
// Input channel i_in carries a transaction with cmd and seed. cmd 1 loads seed
// into the generator and clears the held shuffle word; it returns nothing and
// the block is ready again in the next cycle. cmd 0 requests one draw and
// returns exactly one transaction on o_out carrying a 31-bit value.
// A draw runs from acceptance to o_out.valid through the generator step with
// its 16807 multiply alongside the slot divide by reciprocal multiply, the
// correction, the registered table read, and the swap. One draw is in flight at
// a time, so a new draw is accepted only after the last one has swapped.
// The first draw after reset or after a seed also runs warm-up first,
// one generator step per cycle, filling the table.
// Reset puts the generator state at 1 and clears the held word, so the first
// draw always warms up; the table itself is not cleared.
// o_out has a one-entry output register. The next transaction is taken while
// a result waits; if the receiver stalls, the following draw holds in its
// final step until the register frees.
module shuffled_park_miller_rng_top #(
    parameter int unsigned TABLE_SIZE = spmr_pkg::TableSize
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spmr_in_if.sink     i_in,
    spmr_out_if.source  o_out
);
    import spmr_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    assign i_in.ready = w_in_ready;

    spmr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    spmr_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_seed      (i_in.seed),
        .o_out_valid (o_out.valid),
        .o_out_value (o_out.value),
        .i_out_ready (o_out.ready)
    );

endmodule
